[sv/ioeu_pkg.sv]
// ----------------------------------------------------------------------------
// ioeu_pkg
// Shared types and constants for the intermediate operation execute unit.
// ----------------------------------------------------------------------------
package ioeu_pkg;

  localparam int RegCount = 32;
  localparam int FieldW   = 5;
  localparam int DataW    = 64;
  // address bits used to index the register file; the index fields stay 5 bits
  localparam int AddrW    = ($clog2(RegCount) > FieldW) ? FieldW : $clog2(RegCount);

  typedef enum logic [FieldW-1:0] {
    OpNop       = 5'd0,
    OpMove      = 5'd1,
    OpBranch    = 5'd2,
    OpBranchNz  = 5'd3,
    OpLoadImm   = 5'd4,
    OpAdd       = 5'd5,
    OpAddImm    = 5'd6,
    OpSub       = 5'd7,
    OpSubImm    = 5'd8,
    OpAndImm    = 5'd9,
    OpAndNot    = 5'd10,
    OpOr        = 5'd11,
    OpOrImm     = 5'd12,
    OpShl32     = 5'd13,
    OpShl32Imm  = 5'd14,
    OpShl64Imm  = 5'd15
  } op_t;

  typedef struct packed {
    logic             ok;
    logic             wrote;
    logic [FieldW-1:0] written_reg;
    logic [DataW-1:0]  written_value;
    logic             branch_taken;
    logic [DataW-1:0]  pc_value;
  } result_t;

endpackage

[sv/intermediate_op_execute_unit.sv]
// ----------------------------------------------------------------------------
// intermediate_op_execute_unit
// Executes one intermediate operation per transaction against a 64-bit
// register file and a program counter.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries operation, src_a, src_b, dest
//   and imm. Output channel (out_valid/out_ready) returns one result per
//   input transaction: ok, wrote, written_reg, written_value, branch_taken
//   and pc_value, in order.
//   An accepted input is registered in the operand stage, then in the result
//   register. Throughput: one transaction per cycle while out_ready stays high.
//   The register file is read at acceptance into registered read data; the
//   operation is executed between the operand stage and the result register,
//   and the register file is written as the result is registered. A write
//   made at the same edge an operand is read is forwarded.
//   Reset clears the program counter and marks every register as zero
//   (per-entry valid bits); no clearing pass is needed.
//   When the receiver stalls, the result register holds, the operand stage
//   fills, and in_ready drops until out_ready returns.
// ----------------------------------------------------------------------------
module intermediate_op_execute_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ioeu_pkg::FieldW-1:0]   operation,
  input  logic [ioeu_pkg::FieldW-1:0]   src_a,
  input  logic [ioeu_pkg::FieldW-1:0]   src_b,
  input  logic [ioeu_pkg::FieldW-1:0]   dest,
  input  logic [ioeu_pkg::DataW-1:0]    imm,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          ok,
  output logic                          wrote,
  output logic [ioeu_pkg::FieldW-1:0]   written_reg,
  output logic [ioeu_pkg::DataW-1:0]    written_value,
  output logic                          branch_taken,
  output logic [ioeu_pkg::DataW-1:0]    pc_value
);

  localparam int AW = ioeu_pkg::AddrW;
  localparam int DW = ioeu_pkg::DataW;
  localparam int FW = ioeu_pkg::FieldW;

  // register file storage and per-entry valid bits
  logic [DW-1:0]                 mem [ioeu_pkg::RegCount];
  logic [ioeu_pkg::RegCount-1:0] reg_vld;

  // operand stage
  logic          s1_valid;
  logic [FW-1:0] s1_op;
  logic [FW-1:0] s1_dest;
  logic [DW-1:0] s1_imm;
  logic [FW-1:0] s1_ia;
  logic [FW-1:0] s1_ib;
  logic [DW-1:0] s1_ra;
  logic [DW-1:0] s1_rb;
  logic          s1_ra_ok;
  logic          s1_rb_ok;
  logic          s1_dest_ok;

  // write made at the edge the operand stage was loaded
  logic          fwd_valid;
  logic [FW-1:0] fwd_addr;
  logic [DW-1:0] fwd_val;

  logic [DW-1:0] pc;
  logic          out_vld;
  ioeu_pkg::result_t res;
  ioeu_pkg::result_t res_next;

  logic          accept;
  logic          advance;
  logic          a_in_range;
  logic          b_in_range;
  logic          d_in_range;
  logic [DW-1:0] opa;
  logic [DW-1:0] opb;
  logic [DW-1:0] val;
  logic          op_ok;
  logic          op_wr;
  logic          op_br;
  logic          do_write;
  logic [31:0]   sh32;

  assign advance  = s1_valid && (!out_vld || out_ready);
  assign in_ready = !s1_valid || advance;
  assign accept   = in_valid && in_ready;

  assign a_in_range = 32'(src_a) < ioeu_pkg::RegCount;
  assign b_in_range = 32'(src_b) < ioeu_pkg::RegCount;
  assign d_in_range = 32'(dest)  < ioeu_pkg::RegCount;

  // operands, with forwarding of a write that raced the read; the raced
  // write also raced the valid bit, so it is checked first
  always_comb begin
    if (fwd_valid && fwd_addr == s1_ia) begin
      opa = fwd_val;
    end else if (!s1_ra_ok) begin
      opa = '0;
    end else begin
      opa = s1_ra;
    end
    if (fwd_valid && fwd_addr == s1_ib) begin
      opb = fwd_val;
    end else if (!s1_rb_ok) begin
      opb = '0;
    end else begin
      opb = s1_rb;
    end
  end

  always_comb begin
    val   = '0;
    op_ok = 1'b1;
    op_wr = 1'b1;
    op_br = 1'b0;
    sh32  = '0;
    unique case (s1_op)
      ioeu_pkg::OpNop:      op_wr = 1'b0;
      ioeu_pkg::OpMove:     val = opa;
      ioeu_pkg::OpBranch: begin
        op_wr = 1'b0;
        op_br = 1'b1;
      end
      ioeu_pkg::OpBranchNz: begin
        op_wr = 1'b0;
        op_br = (opa != '0);
      end
      ioeu_pkg::OpLoadImm:  val = s1_imm;
      ioeu_pkg::OpAdd:      val = opa + opb;
      ioeu_pkg::OpAddImm:   val = opa + s1_imm;
      ioeu_pkg::OpSub:      val = opb - opa;
      ioeu_pkg::OpSubImm:   val = opa - s1_imm;
      ioeu_pkg::OpAndImm:   val = opa & s1_imm;
      ioeu_pkg::OpAndNot:   val = opa & ~opb;
      ioeu_pkg::OpOr:       val = opa | opb;
      ioeu_pkg::OpOrImm:    val = opa | s1_imm;
      ioeu_pkg::OpShl32: begin
        sh32 = opa[31:0] << opb[4:0];
        val  = {32'd0, sh32};
      end
      ioeu_pkg::OpShl32Imm: begin
        sh32 = opa[31:0] << s1_imm[4:0];
        val  = {32'd0, sh32};
      end
      ioeu_pkg::OpShl64Imm: val = opa << s1_imm[5:0];
      default: begin
        op_ok = 1'b0;
        op_wr = 1'b0;
      end
    endcase
  end

  assign do_write = op_wr && s1_dest_ok;

  always_comb begin
    res_next.ok            = op_ok;
    res_next.wrote         = do_write;
    res_next.written_reg   = do_write ? s1_dest : '0;
    res_next.written_value = do_write ? val : '0;
    res_next.branch_taken  = op_br;
    res_next.pc_value      = op_br ? s1_imm : pc;
  end

  // register file storage: write on advance, registered reads on accept
  always_ff @(posedge clk) begin
    if (advance && do_write) begin
      mem[s1_dest[AW-1:0]] <= val;
    end
    if (accept) begin
      s1_ra <= mem[src_a[AW-1:0]];
      s1_rb <= mem[src_b[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op      <= operation;
      s1_dest    <= dest;
      s1_imm     <= imm;
      s1_ia      <= src_a;
      s1_ib      <= src_b;
      s1_ra_ok   <= a_in_range && reg_vld[src_a[AW-1:0]];
      s1_rb_ok   <= b_in_range && reg_vld[src_b[AW-1:0]];
      s1_dest_ok <= d_in_range;
      fwd_addr   <= s1_dest;
      fwd_val    <= val;
    end
    if (advance) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_vld   <= 1'b0;
      fwd_valid <= 1'b0;
      reg_vld   <= '0;
      pc        <= '0;
    end else begin
      if (accept) begin
        s1_valid  <= 1'b1;
        fwd_valid <= advance && do_write;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_vld <= 1'b1;
        if (do_write) begin
          reg_vld[s1_dest[AW-1:0]] <= 1'b1;
        end
        if (op_br) begin
          pc <= s1_imm;
        end
      end else if (out_ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  assign out_valid     = out_vld;
  assign ok            = res.ok;
  assign wrote         = res.wrote;
  assign written_reg   = res.written_reg;
  assign written_value = res.written_value;
  assign branch_taken  = res.branch_taken;
  assign pc_value      = res.pc_value;

endmodule

[tb/intermediate_op_execute_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intermediate_op_execute_unit_tb
// Self-checking bench for the execute unit. A shadow copy of the register
// file and program counter predicts every result; results are compared in
// order, field by field. Directed corner cases run first, then ~1150 random
// operations with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module intermediate_op_execute_unit_tb;

  localparam int FieldW   = ioeu_pkg::FieldW;
  localparam int DataW    = ioeu_pkg::DataW;
  localparam int RegCount = ioeu_pkg::RegCount;

  localparam logic [FieldW-1:0] OpFirstBad = 5'd16;
  localparam logic [FieldW-1:0] OpMaxCode  = '1;
  localparam int RandomOps     = 1150;
  localparam int WatchdogLimit = 2000;

  class exec_shadow;
    logic [DataW-1:0] regs [RegCount];
    logic [DataW-1:0] pc;
    ioeu_pkg::result_t outcomes_due[$];
    int mismatches;
    int checked;
    int writes_seen;
    int branches_seen;
    int unknown_seen;

    function new();
      foreach (regs[i]) regs[i] = '0;
      pc = '0;
      mismatches = 0;
      checked = 0;
      writes_seen = 0;
      branches_seen = 0;
      unknown_seen = 0;
    endfunction

    function logic [DataW-1:0] read_reg(logic [FieldW-1:0] idx);
      if (idx < RegCount) return regs[idx];
      return '0;
    endfunction

    // Execute one accepted operation on the shadow state and queue its outcome.
    function void apply_op(logic [FieldW-1:0] op, logic [FieldW-1:0] a_idx,
                           logic [FieldW-1:0] b_idx, logic [FieldW-1:0] d_idx,
                           logic [DataW-1:0] imm_val);
      logic [DataW-1:0] a;
      logic [DataW-1:0] b;
      logic [DataW-1:0] val;
      logic [31:0] lo;
      logic good;
      logic wr;
      logic br;
      ioeu_pkg::result_t res;
      a = read_reg(a_idx);
      b = read_reg(b_idx);
      val = '0;
      good = 1'b1;
      wr = 1'b1;
      br = 1'b0;
      case (op)
        ioeu_pkg::OpNop:      wr = 1'b0;
        ioeu_pkg::OpMove:     val = a;
        ioeu_pkg::OpBranch:   begin wr = 1'b0; br = 1'b1; end
        ioeu_pkg::OpBranchNz: begin wr = 1'b0; br = (a != '0); end
        ioeu_pkg::OpLoadImm:  val = imm_val;
        ioeu_pkg::OpAdd:      val = a + b;
        ioeu_pkg::OpAddImm:   val = a + imm_val;
        ioeu_pkg::OpSub:      val = b - a;
        ioeu_pkg::OpSubImm:   val = a - imm_val;
        ioeu_pkg::OpAndImm:   val = a & imm_val;
        ioeu_pkg::OpAndNot:   val = a & ~b;
        ioeu_pkg::OpOr:       val = a | b;
        ioeu_pkg::OpOrImm:    val = a | imm_val;
        ioeu_pkg::OpShl32: begin
          lo = a[31:0] << b[4:0];
          val = {32'h0, lo};
        end
        ioeu_pkg::OpShl32Imm: begin
          lo = a[31:0] << imm_val[4:0];
          val = {32'h0, lo};
        end
        ioeu_pkg::OpShl64Imm: val = a << imm_val[5:0];
        default: begin
          good = 1'b0;
          wr = 1'b0;
        end
      endcase
      if (wr && d_idx >= RegCount) wr = 1'b0;
      if (wr) regs[d_idx] = val;
      else val = '0;
      if (br) pc = imm_val;
      res.ok = good;
      res.wrote = wr;
      res.written_reg = wr ? d_idx : '0;
      res.written_value = val;
      res.branch_taken = br;
      res.pc_value = pc;
      outcomes_due.push_back(res);
    endfunction

    function void check_field(string name, logic [DataW-1:0] want, logic [DataW-1:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
    endfunction

    function void compare_outcome(ioeu_pkg::result_t got);
      ioeu_pkg::result_t want;
      if (outcomes_due.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing outstanding, expected none actual %h",
                 $time, got);
        return;
      end
      want = outcomes_due.pop_front();
      checked++;
      if (want.wrote) writes_seen++;
      if (want.branch_taken) branches_seen++;
      if (!want.ok) unknown_seen++;
      check_field("ok", DataW'(want.ok), DataW'(got.ok));
      check_field("wrote", DataW'(want.wrote), DataW'(got.wrote));
      check_field("written_reg", DataW'(want.written_reg), DataW'(got.written_reg));
      check_field("written_value", want.written_value, got.written_value);
      check_field("branch_taken", DataW'(want.branch_taken), DataW'(got.branch_taken));
      check_field("pc_value", want.pc_value, got.pc_value);
    endfunction

    function int waiting();
      return outcomes_due.size();
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [FieldW-1:0] operation;
  logic [FieldW-1:0] src_a;
  logic [FieldW-1:0] src_b;
  logic [FieldW-1:0] dest;
  logic [DataW-1:0]  imm;
  logic              out_valid;
  logic              out_ready;
  logic              ok;
  logic              wrote;
  logic [FieldW-1:0] written_reg;
  logic [DataW-1:0]  written_value;
  logic              branch_taken;
  logic [DataW-1:0]  pc_value;

  exec_shadow shadow;
  bit no_gaps;
  int quiet_cycles;
  int ops_sent;

  intermediate_op_execute_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .src_a        (src_a),
    .src_b        (src_b),
    .dest         (dest),
    .imm          (imm),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .ok           (ok),
    .wrote        (wrote),
    .written_reg  (written_reg),
    .written_value(written_value),
    .branch_taken (branch_taken),
    .pc_value     (pc_value)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // narrow index range now and then to force back-to-back dependencies
  function automatic logic [FieldW-1:0] pick_idx();
    if ($urandom_range(0, 99) < 30) return FieldW'($urandom_range(0, 3));
    return FieldW'($urandom_range(0, RegCount - 1));
  endfunction

  function automatic logic [DataW-1:0] pick_imm();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return {$urandom, $urandom};
    if (r < 60) return DataW'($urandom_range(0, 63));
    if (r < 70) return '1;
    if (r < 80) return 64'd1 << $urandom_range(0, DataW - 1);
    if (r < 90) return '0;
    return {32'h0, $urandom};
  endfunction

  function automatic logic [FieldW-1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return FieldW'($urandom_range(OpFirstBad, OpMaxCode));
    if (r < 20) return ioeu_pkg::OpLoadImm;
    return FieldW'($urandom_range(ioeu_pkg::OpNop, ioeu_pkg::OpShl64Imm));
  endfunction

  task automatic send_op(logic [FieldW-1:0] op, logic [FieldW-1:0] a_idx,
                         logic [FieldW-1:0] b_idx, logic [FieldW-1:0] d_idx,
                         logic [DataW-1:0] imm_val);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    src_a     <= a_idx;
    src_b     <= b_idx;
    dest      <= d_idx;
    imm       <= imm_val;
    do @(posedge clk); while (!in_ready);
    shadow.apply_op(op, a_idx, b_idx, d_idx, imm_val);
    ops_sent++;
  endtask

  // result side: check at the edge, then choose ready for the next cycle
  initial begin : result_side
    ioeu_pkg::result_t got;
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (out_valid && out_ready) begin
        got.ok = ok;
        got.wrote = wrote;
        got.written_reg = written_reg;
        got.written_value = written_value;
        got.branch_taken = branch_taken;
        got.pc_value = pc_value;
        shadow.compare_outcome(got);
      end
      if (stall_left > 0 && !no_gaps) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        stall_left = 0;
        out_ready <= 1'b1;
        if (!no_gaps && $urandom_range(0, 99) < 30) stall_left = pick_gap();
      end
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, WatchdogLimit);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    shadow = new();
    no_gaps = 1'b0;
    quiet_cycles = 0;
    ops_sent = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    operation = ioeu_pkg::OpNop;
    src_a = '0;
    src_b = '0;
    dest = '0;
    imm = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners, back to back so each write lands as the next op reads, forwarding where it reads that register
    no_gaps = 1'b1;
    send_op(ioeu_pkg::OpLoadImm,  5'd0,  5'd0,  5'd1, '1);
    send_op(ioeu_pkg::OpLoadImm,  5'd0,  5'd0,  5'd2, 64'h8000_0000_0000_0001);
    send_op(ioeu_pkg::OpLoadImm,  5'd0,  5'd0,  5'd31, 64'd63);
    send_op(ioeu_pkg::OpMove,     5'd1,  5'd0,  5'd3, '0);
    send_op(ioeu_pkg::OpAdd,      5'd1,  5'd2,  5'd4, '0);
    send_op(ioeu_pkg::OpAddImm,   5'd2,  5'd0,  5'd5, '1);
    send_op(ioeu_pkg::OpSub,      5'd1,  5'd2,  5'd6, '0);
    send_op(ioeu_pkg::OpSubImm,   5'd0,  5'd0,  5'd7, 64'd1);
    send_op(ioeu_pkg::OpAndImm,   5'd1,  5'd0,  5'd8, 64'h5555_5555_5555_5555);
    send_op(ioeu_pkg::OpAndNot,   5'd1,  5'd2,  5'd9, '0);
    send_op(ioeu_pkg::OpOr,       5'd2,  5'd8,  5'd10, '0);
    send_op(ioeu_pkg::OpOrImm,    5'd0,  5'd0,  5'd11, '0);
    send_op(ioeu_pkg::OpShl32,    5'd1,  5'd31, 5'd12, '0);   // count 63 wraps to 31
    send_op(ioeu_pkg::OpShl32Imm, 5'd2,  5'd0,  5'd13, 64'd32);
    send_op(ioeu_pkg::OpShl64Imm, 5'd2,  5'd0,  5'd14, 64'd63);
    send_op(ioeu_pkg::OpShl64Imm, 5'd1,  5'd0,  5'd15, 64'd64);
    send_op(ioeu_pkg::OpBranch,   5'd0,  5'd0,  5'd0, '1);
    send_op(ioeu_pkg::OpBranchNz, 5'd0,  5'd0,  5'd0, 64'h1234);  // r0 is zero: not taken
    send_op(ioeu_pkg::OpBranchNz, 5'd1,  5'd0,  5'd0, '0);
    send_op(ioeu_pkg::OpNop,      5'd31, 5'd31, 5'd31, '1);
    send_op(OpFirstBad,           5'd1,  5'd2,  5'd3, 64'h55);
    send_op(OpMaxCode,            5'd31, 5'd31, 5'd31, '1);
    send_op(ioeu_pkg::OpAdd,      5'd1,  5'd1,  5'd1, '0);   // source and destination the same
    send_op(ioeu_pkg::OpLoadImm,  5'd0,  5'd0,  5'd31, '0);
    send_op(ioeu_pkg::OpMove,     5'd31, 5'd0,  5'd0, '0);
    no_gaps = 1'b0;

    for (int i = 0; i < RandomOps; i++) begin
      // every third block of 100 runs with no idling on either side
      no_gaps = ((i / 100) % 3 == 2);
      send_op(pick_op(), pick_idx(), pick_idx(), pick_idx(), pick_imm());
    end
    no_gaps = 1'b0;
    in_valid <= 1'b0;

    while (shadow.waiting() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d operations, %0d results checked: %0d register writes,",
             ops_sent, shadow.checked, shadow.writes_seen);
    $display("%0d branches taken, %0d unknown codes; %0d mismatches.",
             shadow.branches_seen, shadow.unknown_seen, shadow.mismatches);
    if (shadow.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
sv/ioeu_pkg.sv
sv/intermediate_op_execute_unit.sv
tb/intermediate_op_execute_unit_tb.sv
